// ----- rtl/llf_pkg.sv -----
// ----------------------------------------------------------------------------
// llf_pkg
// Shared widths, constants, sequencer step codes and control struct for the
// four-pole ladder low-pass filter.
// ----------------------------------------------------------------------------
package llf_pkg;

    localparam int DATA_W    = 16;
    localparam int RES_W     = 15;
    localparam int OPND_W    = DATA_W + 1;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int STEP_W    = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [DATA_W-1:0] CUTOFF_RST = 16'h4000;
    localparam logic [RES_W-1:0]  RES_RST    = 15'h0000;
    localparam logic [DATA_W-1:0] T_BASE     = 16'h7fff;
    localparam logic [DATA_W-1:0] T_COEF     = 16'h2666;
    localparam logic [DATA_W-1:0] GAIN_COEF  = 16'h59a2;
    localparam logic [DATA_W-1:0] FEED_COEF  = 16'h4ccc;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESONANCE = 2'd1;

    // multiply issue steps; a product is written back one step after issue
    localparam logic [STEP_W-1:0] S_SQ    = 5'd0;
    localparam logic [STEP_W-1:0] S_DEC0  = 5'd1;
    localparam logic [STEP_W-1:0] S_TMUL  = 5'd2;
    localparam logic [STEP_W-1:0] S_F4    = 5'd3;
    localparam logic [STEP_W-1:0] S_FB    = 5'd4;
    localparam logic [STEP_W-1:0] S_FEED0 = 5'd5;
    localparam logic [STEP_W-1:0] S_RES   = 5'd6;
    localparam logic [STEP_W-1:0] S_DEC1  = 5'd7;
    localparam logic [STEP_W-1:0] S_GAIN  = 5'd8;
    localparam logic [STEP_W-1:0] S_FEED1 = 5'd9;
    localparam logic [STEP_W-1:0] S_SCALE = 5'd10;
    localparam logic [STEP_W-1:0] S_DEC2  = 5'd11;
    localparam logic [STEP_W-1:0] S_FEED2 = 5'd12;
    localparam logic [STEP_W-1:0] S_DEC3  = 5'd13;
    localparam logic [STEP_W-1:0] S_FEED3 = 5'd14;

    // pole update steps
    localparam logic [STEP_W-1:0] S_POLE0 = 5'd13;
    localparam logic [STEP_W-1:0] S_POLE1 = 5'd14;
    localparam logic [STEP_W-1:0] S_POLE2 = 5'd15;
    localparam logic [STEP_W-1:0] S_POLE3 = 5'd16;
    localparam logic [STEP_W-1:0] S_LAST  = S_POLE3;

    typedef struct packed {
        logic              run;
        logic [STEP_W-1:0] step;
    } llf_ctl_t;

endpackage

// ----- rtl/llf_mul.sv -----
// ----------------------------------------------------------------------------
// llf_mul
// Shared 17x17 signed multiplier with registered product.
// ----------------------------------------------------------------------------
module llf_mul (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [llf_pkg::OPND_W-1:0] opnd_a,
    input  logic signed [llf_pkg::OPND_W-1:0] opnd_b,
    output logic signed [llf_pkg::PROD_W-1:0] prod
);

    logic signed [llf_pkg::PROD_W-1:0] prod_reg;
    logic signed [llf_pkg::PROD_W-1:0] prod_next;

    assign prod_next = llf_pkg::PROD_W'(opnd_a) * llf_pkg::PROD_W'(opnd_b);
    assign prod      = prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

// ----- rtl/llf_seq.sv -----
// ----------------------------------------------------------------------------
// llf_seq
// Step sequencer: input/output handshake, step counter, output valid.
// ----------------------------------------------------------------------------
module llf_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_ready,
    output logic              out_valid,
    output llf_pkg::llf_ctl_t ctl
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [llf_pkg::STEP_W-1:0]   step_reg;
    logic [llf_pkg::STEP_W-1:0]   step_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         last;
    logic                         advance;

    assign last     = (state_reg == ST_RUN) && (step_reg == llf_pkg::S_LAST);
    // final step waits while the previous result is still pending
    assign advance  = (state_reg == ST_RUN) && !(last && out_valid_reg && !out_ready);
    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign ctl.run  = advance;
    assign ctl.step = step_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                    step_next  = llf_pkg::S_SQ;
                end
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    if (last)
                    begin
                        state_next     = ST_IDLE;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/ladder_lowpass_filter_4pole_unit.sv -----
// ----------------------------------------------------------------------------
// ladder_lowpass_filter_4pole_unit
// Four-pole resonant ladder low-pass filter, 16-bit fixed point, built on one
// shared multiplier under a step sequencer.
// ----------------------------------------------------------------------------
//  channel | signals                                  | dir
//  --------+------------------------------------------+-----
//  in      | in_valid, in_ready, sample_in[15:0]      | in
//  out     | out_valid, out_ready, sample_out[15:0]   | out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| in
//
//  A new sample is taken only once the previous one has run through all
//  steps; this pace is set by the single 17x17 multiplier: 15 products,
//  six of them a dependent chain.
//  Reset presets cutoff, clears resonance and pole state; no clearing pass.
//  The last step holds while the previous result is still not taken.
//  cfg is always ready; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module ladder_lowpass_filter_4pole_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [llf_pkg::DATA_W-1:0]    sample_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [llf_pkg::DATA_W-1:0]    sample_out,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [llf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [llf_pkg::DATA_W-1:0]    cfg_data
);

    llf_pkg::llf_ctl_t                  ctl;
    logic                               mul_en;
    logic signed [llf_pkg::OPND_W-1:0]  opnd_a;
    logic signed [llf_pkg::OPND_W-1:0]  opnd_b;
    logic signed [llf_pkg::PROD_W-1:0]  prod;
    logic        [llf_pkg::DATA_W-1:0]  p13;
    logic        [llf_pkg::DATA_W-1:0]  p15;
    logic        [llf_pkg::DATA_W-1:0]  p16;
    logic        [llf_pkg::STEP_W-1:0]  wb_step;
    logic        [1:0]                  pole_idx;
    logic        [llf_pkg::DATA_W-1:0]  pole_sum;
    logic        [llf_pkg::DATA_W-1:0]  decay_coef;

    logic [llf_pkg::DATA_W-1:0] cutoff_reg;
    logic [llf_pkg::RES_W-1:0]  resonance_reg;
    logic [llf_pkg::DATA_W-1:0] sample_reg;
    logic [llf_pkg::DATA_W-1:0] t_reg;
    logic [llf_pkg::DATA_W-1:0] t_next;
    logic [llf_pkg::DATA_W-1:0] f4_reg;
    logic [llf_pkg::DATA_W-1:0] f4_next;
    logic [llf_pkg::DATA_W-1:0] fb_reg;
    logic [llf_pkg::DATA_W-1:0] fb_next;
    logic [llf_pkg::DATA_W-1:0] x_reg;
    logic [llf_pkg::DATA_W-1:0] x_next;
    logic [llf_pkg::DATA_W-1:0] out_reg;
    logic [llf_pkg::DATA_W-1:0] out_next;
    logic [llf_pkg::DATA_W-1:0] acc_reg       [4];
    logic [llf_pkg::DATA_W-1:0] acc_next      [4];
    logic [llf_pkg::DATA_W-1:0] pole_out_reg  [4];
    logic [llf_pkg::DATA_W-1:0] pole_out_next [4];
    logic [llf_pkg::DATA_W-1:0] pole_prev_reg [4];
    logic [llf_pkg::DATA_W-1:0] pole_prev_next[4];

    llf_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .ctl       (ctl)
    );

    llf_mul u_mul (
        .clk    (clk),
        .en     (mul_en),
        .opnd_a (opnd_a),
        .opnd_b (opnd_b),
        .prod   (prod)
    );

    assign cfg_ready  = 1'b1;
    assign sample_out = out_reg;
    assign decay_coef = ~cutoff_reg;

    // product slices after arithmetic shift, wrapped to 16 bits
    assign p13 = prod[28:13];
    assign p15 = prod[30:15];
    assign p16 = prod[31:16];

    assign wb_step  = ctl.step - 1'b1;
    assign pole_idx = 2'(ctl.step - llf_pkg::S_POLE0);
    assign pole_sum = acc_reg[pole_idx] + x_reg;

    // operand select
    always_comb
    begin
        mul_en = ctl.run;
        opnd_a = '0;
        opnd_b = '0;
        unique case (ctl.step)
            llf_pkg::S_SQ:
            begin
                opnd_a = {1'b0, cutoff_reg};
                opnd_b = {1'b0, cutoff_reg};
            end
            llf_pkg::S_DEC0:
            begin
                opnd_a = {1'b0, decay_coef};
                opnd_b = {pole_out_reg[0][15], pole_out_reg[0]};
            end
            llf_pkg::S_TMUL:
            begin
                opnd_a = {t_reg[15], t_reg};
                opnd_b = {1'b0, llf_pkg::T_COEF};
            end
            llf_pkg::S_F4:
            begin
                opnd_a = {1'b0, f4_reg};
                opnd_b = {1'b0, f4_reg};
            end
            llf_pkg::S_FB:
            begin
                opnd_a = {2'b00, resonance_reg};
                opnd_b = {t_reg[15], t_reg};
            end
            llf_pkg::S_FEED0:
            begin
                opnd_a = {1'b0, llf_pkg::FEED_COEF};
                opnd_b = {pole_prev_reg[0][15], pole_prev_reg[0]};
            end
            llf_pkg::S_RES:
            begin
                opnd_a = {pole_out_reg[3][15], pole_out_reg[3]};
                opnd_b = {fb_reg[15], fb_reg};
            end
            llf_pkg::S_DEC1:
            begin
                opnd_a = {1'b0, decay_coef};
                opnd_b = {pole_out_reg[1][15], pole_out_reg[1]};
            end
            llf_pkg::S_GAIN:
            begin
                opnd_a = {x_reg[15], x_reg};
                opnd_b = {1'b0, llf_pkg::GAIN_COEF};
            end
            llf_pkg::S_FEED1:
            begin
                opnd_a = {1'b0, llf_pkg::FEED_COEF};
                opnd_b = {pole_prev_reg[1][15], pole_prev_reg[1]};
            end
            llf_pkg::S_SCALE:
            begin
                opnd_a = {x_reg[15], x_reg};
                opnd_b = {1'b0, f4_reg};
            end
            llf_pkg::S_DEC2:
            begin
                opnd_a = {1'b0, decay_coef};
                opnd_b = {pole_out_reg[2][15], pole_out_reg[2]};
            end
            llf_pkg::S_FEED2:
            begin
                opnd_a = {1'b0, llf_pkg::FEED_COEF};
                opnd_b = {pole_prev_reg[2][15], pole_prev_reg[2]};
            end
            llf_pkg::S_DEC3:
            begin
                opnd_a = {1'b0, decay_coef};
                opnd_b = {pole_out_reg[3][15], pole_out_reg[3]};
            end
            llf_pkg::S_FEED3:
            begin
                opnd_a = {1'b0, llf_pkg::FEED_COEF};
                opnd_b = {pole_prev_reg[3][15], pole_prev_reg[3]};
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // write-back of the previous step's product, then pole updates
    always_comb
    begin
        t_next   = t_reg;
        f4_next  = f4_reg;
        fb_next  = fb_reg;
        x_next   = x_reg;
        out_next = out_reg;
        for (int i = 0; i < 4; i++)
        begin
            acc_next[i]       = acc_reg[i];
            pole_out_next[i]  = pole_out_reg[i];
            pole_prev_next[i] = pole_prev_reg[i];
        end

        if (ctl.run)
        begin
            unique case (wb_step)
                llf_pkg::S_SQ:
                begin
                    t_next  = p15;
                    f4_next = p16;
                end
                llf_pkg::S_DEC0:  acc_next[0] = p16;
                llf_pkg::S_TMUL:  t_next      = llf_pkg::T_BASE - p16;
                llf_pkg::S_F4:    f4_next     = p16;
                llf_pkg::S_FB:    fb_next     = p15;
                llf_pkg::S_FEED0: acc_next[0] = acc_reg[0] + p16;
                llf_pkg::S_RES:   x_next      = sample_reg - p13;
                llf_pkg::S_DEC1:  acc_next[1] = p16;
                llf_pkg::S_GAIN:  x_next      = p16;
                llf_pkg::S_FEED1: acc_next[1] = acc_reg[1] + p16;
                llf_pkg::S_SCALE: x_next      = p16;
                llf_pkg::S_DEC2:  acc_next[2] = p16;
                llf_pkg::S_FEED2: acc_next[2] = acc_reg[2] + p16;
                llf_pkg::S_DEC3:  acc_next[3] = p16;
                llf_pkg::S_FEED3: acc_next[3] = acc_reg[3] + p16;
                default:
                begin
                end
            endcase

            if (ctl.step >= llf_pkg::S_POLE0)
            begin
                pole_out_next[pole_idx]  = pole_sum;
                pole_prev_next[pole_idx] = x_reg;
                x_next                   = pole_sum;
                if (ctl.step == llf_pkg::S_LAST)
                begin
                    out_next = pole_sum;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg    <= llf_pkg::CUTOFF_RST;
            resonance_reg <= llf_pkg::RES_RST;
            for (int i = 0; i < 4; i++)
            begin
                pole_out_reg[i]  <= '0;
                pole_prev_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    llf_pkg::CFG_CUTOFF:    cutoff_reg    <= cfg_data;
                    llf_pkg::CFG_RESONANCE: resonance_reg <= cfg_data[llf_pkg::RES_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            for (int i = 0; i < 4; i++)
            begin
                pole_out_reg[i]  <= pole_out_next[i];
                pole_prev_reg[i] <= pole_prev_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg <= sample_in;
        end
        t_reg   <= t_next;
        f4_reg  <= f4_next;
        fb_reg  <= fb_next;
        x_reg   <= x_next;
        out_reg <= out_next;
        for (int i = 0; i < 4; i++)
        begin
            acc_reg[i] <= acc_next[i];
        end
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready && ctl.step == llf_pkg::S_SQ)
        else $error("accepted transaction did not start at first step");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(ctl.run) && $past(ctl.step) == llf_pkg::S_LAST)
        else $error("result raised outside the last step");

    a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.run && ctl.step == llf_pkg::S_LAST |=> in_ready && out_valid)
        else $error("last step did not deliver result and free input");

    a_no_run_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !ctl.run && !mul_en)
        else $error("datapath active while idle");
`endif

endmodule

// ----- tb/ladder_lowpass_filter_4pole_unit_tb.sv -----
// ----------------------------------------------------------------------------
// ladder_lowpass_filter_4pole_unit_tb
// Self-checking bench for the four-pole ladder low-pass filter. A short
// stimulus table covers reset behavior, sample extremes, register extremes,
// the large-cutoff wrap and dropped writes to unknown indexes; random phases
// with varied cutoff and resonance follow. Every output sample is compared
// with a bit-exact fixed-point filter model in the bench, or a table row's value.
// ----------------------------------------------------------------------------
module ladder_lowpass_filter_4pole_unit_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_ITEMS   = 850;
    localparam int REPORT_MAX     = 10;
    localparam int DIR_ROWS       = 25;

    localparam logic [llf_pkg::CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
    localparam logic [llf_pkg::CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

    typedef enum logic { ROW_SAMPLE, ROW_CFG } row_kind_t;

    typedef struct packed {
        row_kind_t                          kind;
        logic [llf_pkg::CFG_IDX_W-1:0]      idx;
        logic [llf_pkg::DATA_W-1:0]         data;
        logic                               chk;
        logic signed [llf_pkg::DATA_W-1:0]  want;
    } dir_row_t;

    localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
        '{ROW_SAMPLE, llf_pkg::CFG_CUTOFF,    16'h0000, 1'b1, 16'sh0000},
        '{ROW_SAMPLE, llf_pkg::CFG_CUTOFF,    16'h0000, 1'b1, 16'sh0000},
        '{ROW_SAMPLE, llf_pkg::CFG_CUTOFF,    16'h7fff, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, llf_pkg::CFG_CUTOFF,    16'h8000, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, llf_pkg::CFG_CUTOFF,    16'hffff, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, llf_pkg::CFG_CUTOFF,    16'h0001, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, llf_pkg::CFG_CUTOFF,    16'h5555, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, llf_pkg::CFG_CUTOFF,    16'haaaa, 1'b0, 16'sh0000},
        '{ROW_CFG,    llf_pkg::CFG_RESONANCE, 16'h7fff, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, llf_pkg::CFG_CUTOFF,    16'h7fff, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, llf_pkg::CFG_CUTOFF,    16'h8000, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, llf_pkg::CFG_CUTOFF,    16'h8000, 1'b0, 16'sh0000},
        '{ROW_CFG,    llf_pkg::CFG_CUTOFF,    16'hffff, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, llf_pkg::CFG_CUTOFF,    16'h7fff, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, llf_pkg::CFG_CUTOFF,    16'h8000, 1'b0, 16'sh0000},
        '{ROW_CFG,    CFG_SPARE2,             16'h0000, 1'b0, 16'sh0000},
        '{ROW_CFG,    CFG_SPARE3,             16'hffff, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, llf_pkg::CFG_CUTOFF,    16'h1234, 1'b0, 16'sh0000},
        '{ROW_CFG,    llf_pkg::CFG_CUTOFF,    16'h0000, 1'b0, 16'sh0000},
        '{ROW_CFG,    llf_pkg::CFG_RESONANCE, 16'h8000, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, llf_pkg::CFG_CUTOFF,    16'h7fff, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, llf_pkg::CFG_CUTOFF,    16'h8000, 1'b0, 16'sh0000},
        '{ROW_CFG,    llf_pkg::CFG_CUTOFF,    16'hb505, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, llf_pkg::CFG_CUTOFF,    16'h4000, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, llf_pkg::CFG_CUTOFF,    16'hc000, 1'b0, 16'sh0000}
    };

    logic                                clk;
    logic                                rst_n      = 1'b0;
    logic                                in_valid   = 1'b0;
    logic                                in_ready;
    logic signed [llf_pkg::DATA_W-1:0]   sample_in  = '0;
    logic                                out_valid;
    logic                                out_ready  = 1'b0;
    logic signed [llf_pkg::DATA_W-1:0]   sample_out;
    logic                                cfg_valid  = 1'b0;
    logic                                cfg_ready;
    logic [llf_pkg::CFG_IDX_W-1:0]       cfg_index  = '0;
    logic [llf_pkg::DATA_W-1:0]          cfg_data   = '0;

    // filter model state
    logic [llf_pkg::DATA_W-1:0]          cutoff_mdl;
    logic [llf_pkg::RES_W-1:0]           resonance_mdl;
    logic signed [llf_pkg::DATA_W-1:0]   pole_mdl [4];
    logic signed [llf_pkg::DATA_W-1:0]   prev_in_mdl [4];

    logic signed [llf_pkg::DATA_W-1:0]   expected_samples [$];
    logic signed [llf_pkg::DATA_W-1:0]   oldest_sample;
    int                                  fail_count  = 0;
    int                                  idle_cycles = 0;
    int                                  burst_left  = 0;
    int                                  ready_hold  = 0;

    ladder_lowpass_filter_4pole_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint to_s16(input longint v);
        logic signed [llf_pkg::DATA_W-1:0] w;
        w = v[llf_pkg::DATA_W-1:0];
        return longint'(w);
    endfunction

    // one sample through feedback, gain, cutoff scaling and the four sections
    function automatic logic signed [llf_pkg::DATA_W-1:0] ladder_predict(
        input logic signed [llf_pkg::DATA_W-1:0] s);
        longint f;
        longint sq;
        longint t;
        longint fb;
        longint x;
        longint f4;
        longint decay;
        longint feed;
        f  = longint'(cutoff_mdl);
        sq = f * f;
        t  = to_s16(sq >>> 15);
        t  = to_s16(longint'(llf_pkg::T_BASE) - ((t * longint'(llf_pkg::T_COEF)) >>> 16));
        fb = to_s16((longint'(resonance_mdl) * t) >>> 15);
        x  = longint'(s);
        x  = to_s16(x - ((longint'(pole_mdl[3]) * fb) >>> 13));
        x  = to_s16((x * longint'(llf_pkg::GAIN_COEF)) >>> 16);
        f4 = sq >>> 16;
        f4 = (f4 * f4) >>> 16;
        x  = to_s16((x * f4) >>> 16);
        for (int i = 0; i < 4; i++)
        begin
            decay = to_s16(((longint'(16'hffff) - f) * longint'(pole_mdl[i])) >>> 16);
            feed  = to_s16((longint'(llf_pkg::FEED_COEF) * longint'(prev_in_mdl[i])) >>> 16);
            prev_in_mdl[i] = x[llf_pkg::DATA_W-1:0];
            pole_mdl[i]    = llf_pkg::DATA_W'(to_s16(feed + x + decay));
            x = longint'(pole_mdl[i]);
        end
        return pole_mdl[3];
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t: %s", $realtime, msg);
    endtask

    // burst/gap sender; valid stays high across back-to-back transactions
    task automatic send_sample(input logic signed [llf_pkg::DATA_W-1:0] s, input logic chk,
                               input logic signed [llf_pkg::DATA_W-1:0] want);
        int gap;
        logic signed [llf_pkg::DATA_W-1:0] pred;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        sample_in <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pred = ladder_predict(s);
        expected_samples.push_back(chk ? want : pred);
    endtask

    task automatic write_reg(input logic [llf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [llf_pkg::DATA_W-1:0] val);
        in_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == llf_pkg::CFG_CUTOFF)
            cutoff_mdl = val;
        else if (idx == llf_pkg::CFG_RESONANCE)
            resonance_mdl = val[llf_pkg::RES_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [llf_pkg::DATA_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (ready_hold == 0)
        begin
            case ($urandom_range(0, 3))
                0, 1:
                begin
                    out_ready  <= 1'b1;
                    ready_hold <= $urandom_range(1, 40);
                end
                2:
                begin
                    out_ready  <= 1'b0;
                    ready_hold <= $urandom_range(1, 6);
                end
                default:
                begin
                    out_ready  <= 1'b0;
                    ready_hold <= $urandom_range(10, 30);
                end
            endcase
        end
        else
        begin
            ready_hold <= ready_hold - 1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                note_failure($sformatf("unexpected output transaction, sample_out=%0d",
                                       sample_out));
            end
            else
            begin
                oldest_sample = expected_samples.pop_front();
                if (sample_out !== oldest_sample)
                    note_failure($sformatf("sample_out mismatch: expected %0d, got %0d",
                                           oldest_sample, sample_out));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int sent;
        int phase_len;
        cutoff_mdl    = llf_pkg::CUTOFF_RST;
        resonance_mdl = llf_pkg::RES_RST;
        for (int i = 0; i < 4; i++)
        begin
            pole_mdl[i]    = '0;
            prev_in_mdl[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (DIR_TABLE[r].kind == ROW_CFG)
                write_reg(DIR_TABLE[r].idx, DIR_TABLE[r].data);
            else
                send_sample(DIR_TABLE[r].data, DIR_TABLE[r].chk, DIR_TABLE[r].want);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:       write_reg(llf_pkg::CFG_CUTOFF, 16'h0000);
                1:       write_reg(llf_pkg::CFG_CUTOFF, 16'hffff);
                2:       write_reg(llf_pkg::CFG_CUTOFF, llf_pkg::CUTOFF_RST);
                3:       write_reg(llf_pkg::CFG_CUTOFF, 16'($urandom_range(16'hb000, 16'hffff)));
                default: write_reg(llf_pkg::CFG_CUTOFF, 16'($urandom));
            endcase
            case ($urandom_range(0, 4))
                0:       write_reg(llf_pkg::CFG_RESONANCE, 16'h0000);
                1:       write_reg(llf_pkg::CFG_RESONANCE, 16'h7fff);
                2:       write_reg(llf_pkg::CFG_RESONANCE, 16'hffff);
                default: write_reg(llf_pkg::CFG_RESONANCE, 16'($urandom));
            endcase
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE2 : CFG_SPARE3, 16'($urandom));
            phase_len = $urandom_range(50, 100);
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++)
            begin
                send_sample(pick_sample(), 1'b0, 16'sh0000);
                sent++;
            end
        end

        in_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/llf_pkg.sv
rtl/llf_mul.sv
rtl/llf_seq.sv
rtl/ladder_lowpass_filter_4pole_unit.sv
tb/ladder_lowpass_filter_4pole_unit_tb.sv
